>>> rtl/core/pidc_pkg.sv
// Shared widths, register map, control word layout and microprogram for the PID step.
package pidc_pkg;

	// Fixed point format and datapath widths
	localparam int FRAC_BITS = 16;
	localparam int TIME_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int TIME_W    = 16;
	localparam int HALF_W    = 32;
	localparam int OPER_W    = 33;
	localparam int MUL_W     = 2 * OPER_W;
	localparam int INTEG_W   = 48;
	localparam int INTEG_X_W = INTEG_W + 1;
	localparam int DERIV_W   = 64;
	localparam int PROD_W    = 96;
	localparam int ADDR_W    = 5;
	localparam int IDX_W     = 3;

	localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
	localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

	// Register map
	typedef enum logic [IDX_W-1:0] {
		REG_SETPOINT  = 3'd0,
		REG_GAIN_P    = 3'd1,
		REG_GAIN_I    = 3'd2,
		REG_GAIN_D    = 3'd3,
		REG_STEP_TIME = 3'd4,
		REG_STEP_RATE = 3'd5
	} pidc_reg_t;

	localparam logic [TIME_W-1:0] STEP_TIME_RST = 16'd655;
	localparam logic [DATA_W-1:0] STEP_RATE_RST = 32'd6553600;

	typedef struct packed {
		logic [DATA_W-1:0] setpoint;
		logic [DATA_W-1:0] gain_p;
		logic [DATA_W-1:0] gain_i;
		logic [DATA_W-1:0] gain_d;
		logic [TIME_W-1:0] step_time;
		logic [DATA_W-1:0] step_rate;
	} pidc_cfg_t;

	// Datapath status seen by the sequencer
	typedef struct packed {
		logic out_busy;
		logic gain_d_zero;
	} pidc_stat_t;

	// Control word fields
	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_NO_IN,
		C_OUT_BUSY,
		C_GAIN_D_ZERO
	} cond_t;

	typedef enum logic [2:0] {
		A_ERR,
		A_DIFF,
		A_GAIN_P,
		A_GAIN_I,
		A_GAIN_D
	} asel_t;

	typedef enum logic [2:0] {
		B_TIME,
		B_RATE,
		B_ERR,
		B_INT_LO,
		B_INT_HI,
		B_DER_LO,
		B_DER_HI
	} bsel_t;

	typedef enum logic [1:0] {
		P_HOLD,
		P_LOAD,
		P_ADD_HI
	} prod_op_t;

	typedef enum logic [1:0] {
		S_HOLD,
		S_LOAD,
		S_ADD
	} sum_op_t;

	typedef enum logic [2:0] {
		M_NONE,
		M_ERROR,
		M_DIFF,
		M_INTEG,
		M_DERIV,
		M_OUTPUT
	} misc_t;

	typedef struct packed {
		cond_t    cond;
		logic     waits;
		step_t    target;
		asel_t    a_sel;
		bsel_t    b_sel;
		prod_op_t prod_op;
		sum_op_t  sum_op;
		misc_t    misc;
	} pidc_ctrl_t;

	// Program step addresses
	localparam step_t ST_IDLE  = 4'd0;
	localparam step_t ST_TIME  = 4'd1;
	localparam step_t ST_RATE  = 4'd2;
	localparam step_t ST_PTERM = 4'd3;
	localparam step_t ST_ILO   = 4'd4;
	localparam step_t ST_IHI   = 4'd5;
	localparam step_t ST_DLO   = 4'd6;
	localparam step_t ST_DHI   = 4'd7;
	localparam step_t ST_DSUM  = 4'd8;
	localparam step_t ST_DADD  = 4'd9;
	localparam step_t ST_OUT   = 4'd10;

	// Microprogram ROM
	function automatic pidc_ctrl_t ucode_word(input step_t s);
		pidc_ctrl_t w;
		w.cond    = C_NEVER;
		w.waits   = 1'b0;
		w.target  = ST_IDLE;
		w.a_sel   = A_ERR;
		w.b_sel   = B_TIME;
		w.prod_op = P_HOLD;
		w.sum_op  = S_HOLD;
		w.misc    = M_NONE;
		case (s)
			ST_IDLE: begin
				w.cond   = C_NO_IN;
				w.waits  = 1'b1;
				w.target = ST_TIME;
				w.misc   = M_ERROR;
			end
			ST_TIME: begin
				w.a_sel = A_ERR;
				w.b_sel = B_TIME;
				w.misc  = M_DIFF;
			end
			ST_RATE: begin
				w.a_sel = A_DIFF;
				w.b_sel = B_RATE;
				w.misc  = M_INTEG;
			end
			ST_PTERM: begin
				w.a_sel = A_GAIN_P;
				w.b_sel = B_ERR;
				w.misc  = M_DERIV;
			end
			ST_ILO: begin
				w.a_sel   = A_GAIN_I;
				w.b_sel   = B_INT_LO;
				w.prod_op = P_LOAD;
			end
			ST_IHI: begin
				w.a_sel   = A_GAIN_I;
				w.b_sel   = B_INT_HI;
				w.prod_op = P_LOAD;
				w.sum_op  = S_LOAD;
			end
			ST_DLO: begin
				w.a_sel   = A_GAIN_D;
				w.b_sel   = B_DER_LO;
				w.prod_op = P_ADD_HI;
			end
			ST_DHI: begin
				w.cond    = C_GAIN_D_ZERO;
				w.target  = ST_OUT;
				w.a_sel   = A_GAIN_D;
				w.b_sel   = B_DER_HI;
				w.prod_op = P_LOAD;
				w.sum_op  = S_ADD;
			end
			ST_DSUM: begin
				w.prod_op = P_ADD_HI;
			end
			ST_DADD: begin
				w.sum_op = S_ADD;
			end
			ST_OUT: begin
				w.cond   = C_OUT_BUSY;
				w.waits  = 1'b1;
				w.target = ST_IDLE;
				w.misc   = M_OUTPUT;
			end
			default: begin
				w.cond   = C_NEVER;
				w.waits  = 1'b0;
				w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

>>> rtl/core/pidc_regs.sv
// APB configuration registers for the PID step.
module pidc_regs import pidc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output pidc_cfg_t         cfg
);

	pidc_cfg_t        cfg_q;
	logic             wr_en;
	logic [IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	// Write a register on a completed write transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint  <= '0;
			cfg_q.gain_p    <= '0;
			cfg_q.gain_i    <= '0;
			cfg_q.gain_d    <= '0;
			cfg_q.step_time <= STEP_TIME_RST;
			cfg_q.step_rate <= STEP_RATE_RST;
		end else if (wr_en) begin
			case (idx)
				REG_SETPOINT:  cfg_q.setpoint  <= pwdata;
				REG_GAIN_P:    cfg_q.gain_p    <= pwdata;
				REG_GAIN_I:    cfg_q.gain_i    <= pwdata;
				REG_GAIN_D:    cfg_q.gain_d    <= pwdata;
				REG_STEP_TIME: cfg_q.step_time <= pwdata[TIME_W-1:0];
				REG_STEP_RATE: cfg_q.step_rate <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (idx)
			REG_SETPOINT:  prdata = cfg_q.setpoint;
			REG_GAIN_P:    prdata = cfg_q.gain_p;
			REG_GAIN_I:    prdata = cfg_q.gain_i;
			REG_GAIN_D:    prdata = cfg_q.gain_d;
			REG_STEP_TIME: prdata = DATA_W'(cfg_q.step_time);
			REG_STEP_RATE: prdata = cfg_q.step_rate;
			default:       prdata = '0;
		endcase
	end

endmodule

>>> rtl/core/pidc_seq.sv
// Microprogram sequencer: step counter, control ROM and conditional jumps.
module pidc_seq import pidc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  pidc_stat_t stat,
	output pidc_ctrl_t ctrl,
	output logic       fire,
	output logic       in_ready
);

	step_t pc_q;
	step_t pc_d;
	logic  hit;

	assign ctrl     = ucode_word(pc_q);
	assign in_ready = (ctrl.misc == M_ERROR);

	// Evaluate the step's condition
	always_comb begin
		case (ctrl.cond)
			C_NEVER:       hit = 1'b0;
			C_NO_IN:       hit = !in_valid;
			C_OUT_BUSY:    hit = stat.out_busy;
			C_GAIN_D_ZERO: hit = stat.gain_d_zero;
			default:       hit = 1'b0;
		endcase
	end

	// Wait steps hold in place with their actions dropped; others jump or advance
	assign fire = !(ctrl.waits && hit);

	always_comb begin
		if (ctrl.waits) begin
			pc_d = hit ? pc_q : ctrl.target;
		end else begin
			pc_d = hit ? ctrl.target : STEP_W'(pc_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

`ifndef ASSERT_OFF
	a_pc_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= ST_OUT)
		else $error("step counter left the program");

	a_out_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && ctrl.misc == M_OUTPUT) |=> pc_q == ST_IDLE)
		else $error("sequencer did not return to idle after output");

	a_accept_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == ST_IDLE && in_valid) |=> pc_q == ST_TIME)
		else $error("accepted transaction did not start the program");
`endif

endmodule

>>> rtl/core/pidc_datapath.sv
// PID datapath: error, integral, derivative, shared multiplier and term accumulator.
module pidc_datapath import pidc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pidc_ctrl_t               ctrl,
	input  logic                     fire,
	input  pidc_cfg_t                cfg,
	input  logic signed [DATA_W-1:0] measurement,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic signed [DATA_W-1:0] drive,
	output logic                     clipped,
	output pidc_stat_t               stat
);

	logic signed [DATA_W-1:0]    err_q;
	logic signed [DATA_W-1:0]    last_q;
	logic signed [OPER_W-1:0]    diff_q;
	logic signed [INTEG_W-1:0]   integ_q;
	logic signed [DERIV_W-1:0]   deriv_q;
	logic signed [MUL_W-1:0]     mul_q;
	logic signed [PROD_W-1:0]    prod_q;
	logic signed [PROD_W-1:0]    sum_q;
	logic                        clip_q;
	logic signed [DATA_W-1:0]    drive_q;
	logic                        clipped_q;
	logic                        out_valid_q;

	logic signed [DATA_W:0]      err_wide;
	logic                        err_ovf;
	logic signed [DATA_W-1:0]    err_sat;
	logic signed [INTEG_X_W-1:0] integ_wide;
	logic                        integ_ovf;
	logic signed [INTEG_W-1:0]   integ_sat;
	logic signed [OPER_W-1:0]    mul_a;
	logic signed [OPER_W-1:0]    mul_b;
	logic signed [PROD_W-1:0]    prod_shr;
	logic [PROD_W-DATA_W:0]      sum_top;
	logic                        sum_fits;
	logic signed [DATA_W-1:0]    drive_sat;

	// Saturated error
	assign err_wide = (DATA_W+1)'($signed(cfg.setpoint)) - (DATA_W+1)'(measurement);
	assign err_ovf  = err_wide[DATA_W] ^ err_wide[DATA_W-1];
	assign err_sat  = err_ovf ? (err_wide[DATA_W] ? DATA_MIN : DATA_MAX) : err_wide[DATA_W-1:0];

	// Saturated integral update from the error times interval product
	assign integ_wide = INTEG_X_W'(integ_q) + INTEG_X_W'(mul_q >>> TIME_BITS);
	assign integ_ovf  = integ_wide[INTEG_W] ^ integ_wide[INTEG_W-1];
	assign integ_sat  = integ_ovf ? (integ_wide[INTEG_W] ? INTEG_MIN : INTEG_MAX)
	                              : integ_wide[INTEG_W-1:0];

	// Multiplier operand selection
	always_comb begin
		case (ctrl.a_sel)
			A_ERR:    mul_a = OPER_W'(err_q);
			A_DIFF:   mul_a = diff_q;
			A_GAIN_P: mul_a = OPER_W'($signed(cfg.gain_p));
			A_GAIN_I: mul_a = OPER_W'($signed(cfg.gain_i));
			A_GAIN_D: mul_a = OPER_W'($signed(cfg.gain_d));
			default:  mul_a = '0;
		endcase
	end

	always_comb begin
		case (ctrl.b_sel)
			B_TIME:   mul_b = $signed(OPER_W'(cfg.step_time));
			B_RATE:   mul_b = $signed(OPER_W'(cfg.step_rate));
			B_ERR:    mul_b = OPER_W'(err_q);
			B_INT_LO: mul_b = $signed(OPER_W'(integ_q[HALF_W-1:0]));
			B_INT_HI: mul_b = OPER_W'($signed(integ_q[INTEG_W-1:HALF_W]));
			B_DER_LO: mul_b = $signed(OPER_W'(deriv_q[HALF_W-1:0]));
			B_DER_HI: mul_b = OPER_W'($signed(deriv_q[DERIV_W-1:HALF_W]));
			default:  mul_b = '0;
		endcase
	end

	// Output saturation
	assign prod_shr  = prod_q >>> FRAC_BITS;
	assign sum_top   = sum_q[PROD_W-1:DATA_W-1];
	assign sum_fits  = (&sum_top) | ~(|sum_top);
	assign drive_sat = sum_fits ? sum_q[DATA_W-1:0] : (sum_q[PROD_W-1] ? DATA_MIN : DATA_MAX);

	// Working registers
	always_ff @(posedge clk) begin
		mul_q <= MUL_W'(mul_a) * MUL_W'(mul_b);
		if (fire && ctrl.misc == M_ERROR) begin
			err_q  <= err_sat;
			clip_q <= err_ovf;
		end
		if (fire && ctrl.misc == M_DIFF) begin
			diff_q <= OPER_W'(err_q) - OPER_W'(last_q);
		end
		if (fire && ctrl.misc == M_INTEG && integ_ovf) begin
			clip_q <= 1'b1;
		end
		if (fire && ctrl.misc == M_DERIV) begin
			deriv_q <= DERIV_W'(mul_q >>> FRAC_BITS);
		end
		if (fire && ctrl.misc == M_OUTPUT) begin
			drive_q   <= drive_sat;
			clipped_q <= clip_q | !sum_fits;
		end
		case (ctrl.prod_op)
			P_LOAD:   prod_q <= PROD_W'(mul_q);
			P_ADD_HI: prod_q <= prod_q + (PROD_W'(mul_q) <<< HALF_W);
			default:  ;
		endcase
		case (ctrl.sum_op)
			S_LOAD:  sum_q <= prod_shr;
			S_ADD:   sum_q <= sum_q + prod_shr;
			default: ;
		endcase
	end

	// Controller state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= '0;
			integ_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire && ctrl.misc == M_DIFF) begin
				last_q <= err_q;
			end
			if (fire && ctrl.misc == M_INTEG) begin
				integ_q <= integ_sat;
			end
			if (fire && ctrl.misc == M_OUTPUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign drive            = drive_q;
	assign clipped          = clipped_q;
	assign stat.out_busy    = out_valid_q && !out_ready;
	assign stat.gain_d_zero = (cfg.gain_d == '0);

`ifndef ASSERT_OFF
	a_output_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && ctrl.misc == M_OUTPUT) |=> out_valid_q)
		else $error("result not presented after output step");

	a_rail_on_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && ctrl.misc == M_OUTPUT && !sum_fits) |=>
		clipped_q && (drive_q == DATA_MAX || drive_q == DATA_MIN))
		else $error("saturated drive not at a rail or not flagged");

	a_last_error: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && ctrl.misc == M_DIFF) |=> last_q == $past(err_q))
		else $error("previous error not updated");
`endif

endmodule

>>> rtl/core/pid_controller_step.sv
// Top level of the positional fixed-point PID step.
// Each accepted measurement yields one drive value with a saturation flag. The block
// works on one measurement at a time: a microprogram of eleven steps runs the error,
// integral and derivative updates and the three gain terms through one shared 33x33
// signed multiplier, which is used seven times per measurement. A measurement is
// accepted in the idle step and its result is loaded into the output register in the
// output step; with gain_d at zero the two derivative-term steps are skipped. The next
// measurement is accepted the cycle after the result is loaded, so a new measurement
// is taken only once the previous one is through, and later still while a finished
// result is waiting to be taken.
// Configuration registers sit on an APB port at byte addresses 4*i and should be
// written only while the block is idle.
module pid_controller_step import pidc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DATA_W-1:0] measurement,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] drive,
	output logic                     clipped
);

	pidc_cfg_t  cfg;
	pidc_ctrl_t ctrl;
	pidc_stat_t stat;
	logic       fire;

	// Configuration registers
	pidc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer
	pidc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.ctrl     (ctrl),
		.fire     (fire),
		.in_ready (in_ready)
	);

	// Datapath
	pidc_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.fire        (fire),
		.cfg         (cfg),
		.measurement (measurement),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.drive       (drive),
		.clipped     (clipped),
		.stat        (stat)
	);

endmodule

>>> tb/sv/pid_controller_step_tb.sv
// Self-checking testbench for the PID step: register port, directed limits, random runs.
module pid_controller_step_tb;
	import pidc_pkg::*;

	localparam int QUIET_LIMIT      = 2000;
	localparam int SETTLE_CYCLES    = 16;
	localparam int LONG_HOLD        = 300;
	localparam int RANDOM_PHASES    = 12;
	localparam int PHASE_ITEMS      = 150;
	localparam int PRINT_LIMIT      = 100;
	localparam int INTEG_PUSH_ITEMS = 40;

	// Register indexes that decode to nothing
	localparam logic [IDX_W-1:0] IDX_UNMAPPED_LO = 3'd6;
	localparam logic [IDX_W-1:0] IDX_UNMAPPED_HI = 3'd7;

	localparam logic signed [DATA_W-1:0] ONE_Q16 = 32'sh0001_0000;

	// Rails widened for exact arithmetic
	localparam logic signed [127:0] WIDE_DATA_MAX  = DATA_MAX;
	localparam logic signed [127:0] WIDE_DATA_MIN  = DATA_MIN;
	localparam logic signed [127:0] WIDE_INTEG_MAX = INTEG_MAX;
	localparam logic signed [127:0] WIDE_INTEG_MIN = INTEG_MIN;

	typedef struct packed {
		logic signed [DATA_W-1:0] drive;
		logic                     clipped;
	} pid_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [ADDR_W-1:0]        paddr;
	logic [DATA_W-1:0]        pwdata;
	logic [DATA_W-1:0]        prdata;
	logic                     pready;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [DATA_W-1:0] measurement;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [DATA_W-1:0] drive;
	logic                     clipped;

	// Controller copy: registers and loop state
	logic signed [DATA_W-1:0]  sp_reg;
	logic signed [DATA_W-1:0]  kp_reg;
	logic signed [DATA_W-1:0]  ki_reg;
	logic signed [DATA_W-1:0]  kd_reg;
	logic [TIME_W-1:0]         dt_reg;
	logic [DATA_W-1:0]         rate_reg;
	logic signed [INTEG_W-1:0] integ_acc;
	logic signed [DATA_W-1:0]  model_last_err;

	pid_result_t pending_results[$];
	pid_result_t next_result;

	bit idle_on      = 1'b1;
	int hold_request = 0;
	int mismatches   = 0;
	int items_sent   = 0;
	int results_seen = 0;
	int clipped_seen = 0;
	int reg_writes   = 0;
	int quiet_cycles = 0;

	pid_controller_step dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.measurement (measurement),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.drive       (drive),
		.clipped     (clipped)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t ERROR %s: got %h, want %h", $time, what, got, want);
	endtask

	// Advance the controller copy by one sample and return the drive it produces
	function automatic pid_result_t step_pid(input logic signed [DATA_W-1:0] meas);
		logic signed [127:0] err;
		logic signed [127:0] acc;
		logic signed [127:0] deriv;
		logic signed [127:0] total;
		pid_result_t r;
		r.clipped = 1'b0;
		err = sp_reg - meas;
		if (err > WIDE_DATA_MAX) begin
			err = WIDE_DATA_MAX;
			r.clipped = 1'b1;
		end
		if (err < WIDE_DATA_MIN) begin
			err = WIDE_DATA_MIN;
			r.clipped = 1'b1;
		end
		// integrate with floor rounding, hold at the 48-bit rails
		acc = integ_acc + ((err * $signed({1'b0, dt_reg})) >>> TIME_BITS);
		if (acc > WIDE_INTEG_MAX) begin
			acc = WIDE_INTEG_MAX;
			r.clipped = 1'b1;
		end
		if (acc < WIDE_INTEG_MIN) begin
			acc = WIDE_INTEG_MIN;
			r.clipped = 1'b1;
		end
		integ_acc = acc[INTEG_W-1:0];
		// difference times reciprocal interval, never clamped on its own
		deriv = ((err - model_last_err) * $signed({1'b0, rate_reg})) >>> FRAC_BITS;
		model_last_err = err[DATA_W-1:0];
		total = ((kp_reg * err) >>> FRAC_BITS) + ((ki_reg * integ_acc) >>> FRAC_BITS)
			+ ((kd_reg * deriv) >>> FRAC_BITS);
		if (total > WIDE_DATA_MAX) begin
			r.drive = DATA_MAX;
			r.clipped = 1'b1;
		end else if (total < WIDE_DATA_MIN) begin
			r.drive = DATA_MIN;
			r.clipped = 1'b1;
		end else begin
			r.drive = total[DATA_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] reg_value(input logic [IDX_W-1:0] idx);
		case (idx)
			REG_SETPOINT:  return sp_reg;
			REG_GAIN_P:    return kp_reg;
			REG_GAIN_I:    return ki_reg;
			REG_GAIN_D:    return kd_reg;
			REG_STEP_TIME: return {{(DATA_W-TIME_W){1'b0}}, dt_reg};
			REG_STEP_RATE: return rate_reg;
			default:       return '0;
		endcase
	endfunction

	// APB write: setup cycle, then access until pready
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_SETPOINT:  sp_reg = value;
			REG_GAIN_P:    kp_reg = value;
			REG_GAIN_I:    ki_reg = value;
			REG_GAIN_D:    kd_reg = value;
			REG_STEP_TIME: dt_reg = value[TIME_W-1:0];
			REG_STEP_RATE: rate_reg = value;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// APB read of every mapped register, compared with the controller copy
	task automatic check_all_regs();
		for (int i = 0; i <= int'(REG_STEP_RATE); i++) begin
			@(negedge clk);
			psel    = 1'b1;
			penable = 1'b0;
			pwrite  = 1'b0;
			paddr   = {i[IDX_W-1:0], 2'b00};
			@(negedge clk);
			penable = 1'b1;
			@(posedge clk);
			while (!pready) @(posedge clk);
			if (prdata !== reg_value(i[IDX_W-1:0]))
				report_mismatch($sformatf("register %0d readback", i), prdata,
					reg_value(i[IDX_W-1:0]));
			@(negedge clk);
			psel    = 1'b0;
			penable = 1'b0;
		end
	endtask

	// Offer one measurement, with an optional idle burst first; hold until taken
	task automatic send_measurement(input logic signed [DATA_W-1:0] value);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 10);
			@(negedge clk);
			in_valid    = 1'b0;
			measurement = $urandom;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid    = 1'b1;
		measurement = value;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_results.push_back(step_pid(value));
		items_sent++;
	endtask

	// Drop valid, wait out every pending result, then let the block go idle
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_extreme();
		case ($urandom_range(0, 4))
			0:       return DATA_MAX;
			1:       return DATA_MIN;
			2:       return '0;
			3:       return -32'sd1;
			default: return 32'sd1;
		endcase
	endfunction

	// Mostly samples near the setpoint, some anywhere, a few at the rails
	function automatic logic signed [DATA_W-1:0] random_measurement();
		case ($urandom_range(0, 9))
			0:       return pick_extreme();
			1, 2, 3: return $urandom;
			default: return sp_reg + ($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] random_gain();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return $signed($urandom_range(0, 32'h0000_0080)) - 32'sh40;
			2:       return $signed($urandom_range(0, 32'h0000_8000)) - 32'sh4000;
			3:       return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
			4:       return $urandom;
			default: return pick_extreme();
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] random_rate();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'd1;
			3:       return $urandom;
			default: return $urandom_range(32'h0001_0000, 32'h03E8_0000);
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] random_time();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return 32'h0000_FFFF;
			2:       return 32'd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_register_access();
		check_all_regs();
		write_reg(REG_SETPOINT, DATA_MAX);
		write_reg(REG_GAIN_P, DATA_MIN);
		write_reg(REG_GAIN_I, DATA_MAX);
		write_reg(REG_GAIN_D, DATA_MIN);
		write_reg(REG_STEP_TIME, 32'h0000_FFFF);
		write_reg(REG_STEP_RATE, 32'hFFFF_FFFF);
		check_all_regs();
		write_reg(REG_SETPOINT, DATA_MIN);
		write_reg(REG_GAIN_P, DATA_MAX);
		write_reg(REG_GAIN_I, DATA_MIN);
		write_reg(REG_GAIN_D, DATA_MAX);
		write_reg(REG_STEP_TIME, 32'd1);
		write_reg(REG_STEP_RATE, 32'd1);
		check_all_regs();
	endtask

	// Error saturation in both directions with unity proportional gain
	task automatic test_error_limits();
		write_reg(REG_SETPOINT, '0);
		write_reg(REG_GAIN_P, ONE_Q16);
		write_reg(REG_GAIN_I, '0);
		write_reg(REG_GAIN_D, '0);
		write_reg(REG_STEP_TIME, 32'd655);
		write_reg(REG_STEP_RATE, 32'd6553600);
		send_measurement('0);
		send_measurement(DATA_MAX);
		send_measurement(DATA_MIN);
		send_measurement(32'sd1);
		send_measurement(-32'sd1);
		settle();
		write_reg(REG_SETPOINT, DATA_MAX);
		send_measurement(DATA_MIN);
		settle();
		write_reg(REG_SETPOINT, DATA_MIN);
		send_measurement(DATA_MAX);
		send_measurement(32'sd1);
		settle();
	endtask

	// Drive saturation at both rails through extreme proportional gains
	task automatic test_gain_limits();
		write_reg(REG_SETPOINT, '0);
		write_reg(REG_GAIN_P, DATA_MAX);
		send_measurement(32'shFFF0_0000);
		send_measurement(32'sh0010_0000);
		settle();
		write_reg(REG_GAIN_P, DATA_MIN);
		send_measurement(32'shFFF0_0000);
		send_measurement(32'sh0010_0000);
		settle();
	endtask

	// Zero interval freezes the integral; zero rate kills the derivative
	task automatic test_zero_interval_and_rate();
		write_reg(REG_GAIN_P, '0);
		write_reg(REG_GAIN_I, ONE_Q16);
		write_reg(REG_STEP_TIME, '0);
		send_measurement(32'sh0123_4567);
		send_measurement(-32'sh0765_4321);
		settle();
		write_reg(REG_STEP_TIME, 32'd655);
		write_reg(REG_STEP_RATE, '0);
		write_reg(REG_GAIN_D, DATA_MAX);
		send_measurement(32'sh0040_0000);
		send_measurement(-32'sh0040_0000);
		settle();
	endtask

	// Derivative term skipped with zero gain, then at full scale
	task automatic test_derivative_path();
		write_reg(REG_GAIN_D, '0);
		write_reg(REG_GAIN_I, 32'sd16);
		write_reg(REG_GAIN_P, 32'sh0000_8000);
		write_reg(REG_STEP_TIME, 32'h0000_FFFF);
		write_reg(REG_STEP_RATE, 32'hFFFF_FFFF);
		send_measurement(32'sh0000_1000);
		send_measurement(-32'sh0000_1000);
		settle();
		write_reg(REG_GAIN_D, DATA_MIN);
		send_measurement(32'sh0000_0100);
		send_measurement(DATA_MAX);
		settle();
	endtask

	// Upper bits of a narrow register are dropped; unmapped writes change nothing
	task automatic test_unmapped_and_wide_writes();
		write_reg(REG_STEP_TIME, 32'hFFFF_0001);
		write_reg(IDX_UNMAPPED_LO, 32'hDEAD_BEEF);
		write_reg(IDX_UNMAPPED_HI, 32'h1234_5678);
		check_all_regs();
		write_reg(REG_GAIN_D, 32'sh0000_0100);
		write_reg(REG_STEP_RATE, 32'd6553600);
		send_measurement(32'sh0002_0000);
		send_measurement(-32'sh0002_0000);
		settle();
	endtask

	// Random samples over a series of settings, rails first and last
	task automatic test_random_phases();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0) begin
				write_reg(REG_SETPOINT, DATA_MIN);
				write_reg(REG_GAIN_P, DATA_MIN);
				write_reg(REG_GAIN_I, DATA_MIN);
				write_reg(REG_GAIN_D, DATA_MIN);
				write_reg(REG_STEP_TIME, 32'd1);
				write_reg(REG_STEP_RATE, 32'd1);
			end else if (p == RANDOM_PHASES - 1) begin
				write_reg(REG_SETPOINT, DATA_MAX);
				write_reg(REG_GAIN_P, DATA_MAX);
				write_reg(REG_GAIN_I, DATA_MAX);
				write_reg(REG_GAIN_D, DATA_MAX);
				write_reg(REG_STEP_TIME, 32'h0000_FFFF);
				write_reg(REG_STEP_RATE, 32'hFFFF_FFFF);
			end else begin
				write_reg(REG_SETPOINT, ($urandom_range(0, 1) == 0) ? pick_extreme() :
					$signed($urandom));
				write_reg(REG_GAIN_P, random_gain());
				write_reg(REG_GAIN_I, random_gain());
				write_reg(REG_GAIN_D, random_gain());
				write_reg(REG_STEP_TIME, random_time());
				write_reg(REG_STEP_RATE, random_rate());
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// stall the result side long enough to back up the input
				if (p == 3 && n == 40)
					hold_request = LONG_HOLD;
				send_measurement(random_measurement());
			end
			settle();
		end
	endtask

	// Push the integral hard at full rate, then pull it back
	task automatic test_integral_limit();
		logic signed [DATA_W-1:0] target;
		idle_on = 1'b0;
		if (integ_acc >= 0)
			target = DATA_MAX;
		else
			target = DATA_MIN;
		write_reg(REG_SETPOINT, target);
		write_reg(REG_GAIN_P, '0);
		write_reg(REG_GAIN_I, 32'sd1);
		write_reg(REG_GAIN_D, '0);
		write_reg(REG_STEP_TIME, 32'h0000_FFFF);
		repeat (INTEG_PUSH_ITEMS) send_measurement('0);
		settle();
		write_reg(REG_SETPOINT, '0);
		repeat (3) send_measurement(target);
		settle();
	endtask

	// Result side: random stall bursts plus requested long hold-offs
	initial begin : result_sink
		int hold;
		hold      = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold = hold_request;
				hold_request = 0;
			end
			if (hold > 0) begin
				out_ready = 1'b0;
				hold--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				hold = $urandom_range(0, 9);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// Compare each result transaction with the oldest pending prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", drive, '0);
			end else begin
				next_result = pending_results.pop_front();
				if (drive !== next_result.drive)
					report_mismatch("drive", drive, next_result.drive);
				if (clipped !== next_result.clipped)
					report_mismatch("clipped", DATA_W'(clipped), DATA_W'(next_result.clipped));
				if (next_result.clipped)
					clipped_seen++;
				results_seen++;
			end
		end
	end

	// Stop the run when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
				$display("pid_controller_step: mismatch");
				$finish;
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		in_valid       = 1'b0;
		measurement    = '0;
		sp_reg         = '0;
		kp_reg         = '0;
		ki_reg         = '0;
		kd_reg         = '0;
		dt_reg         = STEP_TIME_RST;
		rate_reg       = STEP_RATE_RST;
		integ_acc      = '0;
		model_last_err = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_access();
		test_error_limits();
		test_gain_limits();
		test_zero_interval_and_rate();
		test_derivative_path();
		test_unmapped_and_wide_writes();
		test_random_phases();
		test_integral_limit();

		$display("covered %0d samples, %0d results checked (%0d saturated), %0d register writes",
			items_sent, results_seen, clipped_seen, reg_writes);
		$display("error and drive rails, zero interval and rate, %0d random settings, %s",
			RANDOM_PHASES, "integral pushed at full rate");
		if (mismatches == 0)
			$display("pid_controller_step: match");
		else
			$display("pid_controller_step: mismatch");
		$finish;
	end

endmodule
